@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console character writer package
// Geometry constants, character codes, command classes and the record types
// shared by the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// Screen geometry and tab spacing.
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STEP = 8;

	// Field widths.
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int ADDR_W     = 11;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 4;
	localparam int ATTR_W     = 2 * COLOR_W;
	localparam int VALUE_W    = ATTR_W + CHAR_W;
	localparam int LIN_W      = ROW_W + COL_W + 1;
	localparam int ROW_EXT_W  = ROW_W + 1;
	localparam int COL_EXT_W  = COL_W + 1;

	// Queue sizing; the depth is a power of two so the pointers wrap freely.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;
	localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;
	localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

	// Input kinds.
	localparam logic KIND_PUT   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Character codes with special handling.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	// Command classes produced by the front end.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_PRINT     = 3'd0;
	localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd1;
	localparam logic [OP_W-1:0] OP_RETURN    = 3'd2;
	localparam logic [OP_W-1:0] OP_TAB       = 3'd3;
	localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic               cell_write;
		logic [ADDR_W-1:0]  cell_address;
		logic [VALUE_W-1:0] cell_value;
		logic               fill_screen;
		logic [ADDR_W-1:0]  cursor_position;
	} result_t;

	// Linear cell index, row times the column count plus the column,
	// folded into the address width.
	function automatic logic [ADDR_W-1:0] linear(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [LIN_W-1:0] prod;
		prod = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
		return prod[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/tcw_front.sv @@
// ----------------------------------------------------------------------------
// Text console front end
// Decodes an incoming item into a command class and the character to print.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; (
	input  wire logic              kind,
	input  wire logic [CHAR_W-1:0] char_code,
	output cmd_t                   cmd
);

	always_comb begin
		cmd.ch = char_code;
		if (kind == KIND_CLEAR) begin
			cmd.op = OP_CLEAR;
		end else begin
			case (char_code)
				CH_NEWLINE:   cmd.op = OP_NEWLINE;
				CH_RETURN:    cmd.op = OP_RETURN;
				CH_TAB:       cmd.op = OP_TAB;
				CH_BACKSPACE: cmd.op = OP_BACKSPACE;
				default:      cmd.op = OP_PRINT;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/tcw_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// Text console command queue
// A short first-in first-out queue of decoded commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_queue import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ design/tcw_back.sv @@
// ----------------------------------------------------------------------------
// Text console back end
// Holds the cursor, does one command a cycle while its result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [ATTR_W-1:0]  attr,
	input  cmd_t                    cmd,
	input  wire logic               cmd_empty,
	output logic                    cmd_pop,
	input  wire logic               pop,
	output logic                    empty,
	output logic                    cell_write,
	output logic [ADDR_W-1:0]       cell_address,
	output logic [VALUE_W-1:0]      cell_value,
	output logic                    fill_screen,
	output logic [ADDR_W-1:0]       cursor_position
);

	logic [ROW_W-1:0]  cursor_row_q;
	logic [COL_W-1:0]  cursor_column_q;
	result_t           res_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic              out_pop;
	logic [ROW_EXT_W-1:0] row_n;
	logic [COL_EXT_W-1:0] col_n;
	logic [ROW_W-1:0]  row_f;
	logic [COL_W-1:0]  col_f;
	logic [COL_W-1:0]  addr_col;
	result_t           res;
	result_t           head;

	assign empty   = (count_q == '0);
	assign out_pop = pop && !empty;
	assign cmd_pop = !cmd_empty && ((count_q != QCNT_W'(QUEUE_DEPTH)) || out_pop);

	// Backspace writes the cell left of the cursor, printing the cell under it.
	assign addr_col = (cmd.op == OP_BACKSPACE) ? (cursor_column_q - 1'b1) : cursor_column_q;

	always_comb begin
		row_n            = {1'b0, cursor_row_q};
		col_n            = {1'b0, cursor_column_q};
		res.cell_write   = 1'b0;
		res.cell_address = '0;
		res.cell_value   = '0;
		res.fill_screen  = 1'b0;
		case (cmd.op)
			OP_CLEAR: begin
				row_n           = '0;
				col_n           = '0;
				res.fill_screen = 1'b1;
				res.cell_value  = {attr, CH_BLANK};
			end
			OP_NEWLINE: begin
				row_n = row_n + 1'b1;
				col_n = '0;
			end
			OP_RETURN: begin
				col_n = '0;
			end
			OP_TAB: begin
				col_n = col_n + COL_EXT_W'(TAB_STEP);
			end
			OP_BACKSPACE: begin
				if (cursor_column_q != '0) begin
					col_n            = {1'b0, addr_col};
					res.cell_write   = 1'b1;
					res.cell_address = linear(cursor_row_q, addr_col);
					res.cell_value   = {attr, CH_BLANK};
				end
			end
			OP_PRINT: begin
				col_n            = col_n + 1'b1;
				res.cell_write   = 1'b1;
				res.cell_address = linear(cursor_row_q, addr_col);
				res.cell_value   = {attr, cmd.ch};
			end
			default: begin
				row_n = {1'b0, cursor_row_q};
			end
		endcase
		// The column wraps into the next row first, then the row wraps home.
		if (col_n >= COL_EXT_W'(COLUMNS)) begin
			row_n = row_n + 1'b1;
			col_n = '0;
		end
		if (row_n >= ROW_EXT_W'(ROWS)) begin
			row_n = '0;
			col_n = '0;
		end
		row_f               = row_n[ROW_W-1:0];
		col_f               = col_n[COL_W-1:0];
		res.cursor_position = linear(row_f, col_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q    <= '0;
			cursor_column_q <= '0;
			wr_ptr_q        <= '0;
			rd_ptr_q        <= '0;
			count_q         <= '0;
		end else begin
			if (cmd_pop) begin
				cursor_row_q    <= row_f;
				cursor_column_q <= col_f;
				wr_ptr_q        <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (cmd_pop && !out_pop) begin
				count_q <= count_q + 1'b1;
			end else if (out_pop && !cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q[wr_ptr_q] <= res;
		end
	end

	assign head            = res_q[rd_ptr_q];
	assign cell_write      = head.cell_write;
	assign cell_address    = head.cell_address;
	assign cell_value      = head.cell_value;
	assign fill_screen     = head.fill_screen;
	assign cursor_position = head.cursor_position;

`ifndef NO_ASSERTIONS
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_row_q < ROW_W'(ROWS))
		else $error("cursor row left the screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		COL_EXT_W'(cursor_column_q) < COL_EXT_W'(COLUMNS))
		else $error("cursor column left the screen");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflowed");

	a_write_or_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(cell_write && fill_screen))
		else $error("result both writes a cell and fills the screen");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.op == OP_CLEAR) |=> (cursor_row_q == '0 && cursor_column_q == '0))
		else $error("clear item did not home the cursor");
`endif

endmodule

`default_nettype wire

@@ design/text_console_char_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console character writer
// Turns character items into text-mode cell writes and cursor positions.
// ----------------------------------------------------------------------------
// Usage. Items enter through a queue-like port: an item (kind, char_code) is
// taken at a rising edge with push high and full low. Every item gives
// exactly one result, presented while empty is low and taken at a rising
// edge with pop high. A result carries an optional single cell write, a
// request to fill the whole screen with blanks (clear items), and the new
// linear cursor position.
// Throughput: one item per cycle is sustained while results are taken. Each
// item is registered in the command queue, its result in the result queue.
// The back end sets the rate; it updates the cursor and forms both linear
// addresses (two constant multiplications) combinationally for each item.
// When the receiver stalls, results collect in a two-entry result queue and
// then decoded commands in a two-entry command queue; full rises once both
// are occupied, so at most four items are in flight.
// The colour registers are written over the cfg port, which is always ready.
// Reset puts the cursor at home, empties both queues and sets the colours to
// light grey on black.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_top import tcw_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Item input.
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   kind,
	input  wire logic [CHAR_W-1:0]      char_code,
	// Result output.
	output logic                        empty,
	input  wire logic                   pop,
	output logic                        cell_write,
	output logic [ADDR_W-1:0]           cell_address,
	output logic [VALUE_W-1:0]          cell_value,
	output logic                        fill_screen,
	output logic [ADDR_W-1:0]           cursor_position,
	// Configuration writes.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [COLOR_W-1:0] foreground_q;
	logic [COLOR_W-1:0] background_q;
	cmd_t               front_cmd;
	cmd_t               queue_cmd;
	logic               queue_empty;
	logic               queue_pop;

	// Colour registers; writes to unknown indices are dropped, as are the
	// data bits above the colour nibble.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreground_q <= FOREGROUND_RESET;
			background_q <= BACKGROUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FOREGROUND: foreground_q <= cfg_data[COLOR_W-1:0];
				CFG_BACKGROUND: background_q <= cfg_data[COLOR_W-1:0];
				default: begin
					foreground_q <= foreground_q;
				end
			endcase
		end
	end

	// The front end classifies each item as it is taken.
	tcw_front u_front (
		.kind      (kind),
		.char_code (char_code),
		.cmd       (front_cmd)
	);

	// The command queue lets the front keep accepting while the back stalls.
	tcw_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (queue_pop),
		.rdata  (queue_cmd),
		.empty  (queue_empty)
	);

	// The back end owns the cursor and the result queue.
	tcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.attr            ({background_q, foreground_q}),
		.cmd             (queue_cmd),
		.cmd_empty       (queue_empty),
		.cmd_pop         (queue_pop),
		.pop             (pop),
		.empty           (empty),
		.cell_write      (cell_write),
		.cell_address    (cell_address),
		.cell_value      (cell_value),
		.fill_screen     (fill_screen),
		.cursor_position (cursor_position)
	);

endmodule

`default_nettype wire
